FILE: src/assert_macros.svh
// shared assertion forms for the rtl folder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, skipped while in reset
`define ASSERT_SAME(name, clock, reset, cond, prop) \
  name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
    else $error("assertion failed: name");

// next-cycle implication, skipped while in reset
`define ASSERT_NEXT(name, clock, reset, cond, prop) \
  name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
    else $error("assertion failed: name");

`endif

FILE: src/frcl_pkg.sv
`default_nettype none
package frcl_pkg;

  localparam int NODE_W    = 10;
  localparam int NODES     = 1 << NODE_W;
  localparam int LABEL_W   = 10;
  localparam int CNT_W     = 11;
  localparam int MAX_NODES = 1024;
  localparam int STEP_W    = $clog2(MAX_NODES + 1);
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [LABEL_W-1:0] label_t;
  typedef logic [CNT_W-1:0]   lab_cnt_t;
  typedef logic [STEP_W-1:0]  step_t;

  typedef enum logic {
    KIND_LOAD    = 1'b0,
    KIND_RESOLVE = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_LABEL,
    ST_EMIT_NEW,
    ST_EMIT_MEM,
    ST_NO_ROOT
  } state_t;

  typedef struct packed {
    node_t parent;
    logic  root;
  } node_ent_t;

  typedef struct packed {
    logic   valid;
    label_t label;
  } lab_ent_t;

  typedef struct packed {
    logic   last;
    logic   no_root;
    logic   new_cluster;
    node_t  member_index;
    label_t cluster_label;
  } out_word_t;

endpackage
`default_nettype wire

FILE: src/forest_root_cluster_labeling_top.sv
// load word: written to the node and label memories at acceptance
// resolve word: a walk up the tree (one node memory read per link), then a label memory
//   read-modify-write, then 0, 1 or 2 result words; the next input is taken once the last
//   result is registered
// after rst the label memory is swept clear, one entry a cycle, with s_tready low
`default_nettype none
module forest_root_cluster_labeling_top import frcl_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // node_index, parent_index, is_root
  input  wire logic                  s_tuser,   // kind
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // cluster_label, member_index, new_cluster,
                                                // no_root
  output logic                       m_tlast
);

  `include "assert_macros.svh"

  state_t    state, state_next;
  node_ent_t node_mem [NODES];
  lab_ent_t  lab_mem  [NODES];
  node_ent_t node_rd;
  lab_ent_t  lab_rd;

  node_t     node_ra;
  logic      node_we;
  node_ent_t node_wd;
  node_t     lab_wa;
  logic      lab_we;
  lab_ent_t  lab_wd;

  node_t     clr_cnt;
  node_t     r;
  node_t     node_q;
  step_t     steps;
  label_t    lab;
  lab_cnt_t  next_label;

  out_word_t out_q;
  out_word_t out_word;
  logic      out_load;
  logic      out_free;
  logic      accept;

  node_t     in_node;
  node_t     in_parent;
  logic      in_root;
  kind_t     in_kind;

  assign in_node   = s_tdata[NODE_W-1:0];
  assign in_parent = s_tdata[2*NODE_W-1:NODE_W];
  assign in_root   = s_tdata[2*NODE_W];
  assign in_kind   = kind_t'(s_tuser);

  assign out_free = !m_tvalid || m_tready;

  // memories, registered read
  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[in_node] <= node_wd;
    end
    node_rd <= node_mem[node_ra];
  end

  always_ff @(posedge clk) begin
    if (lab_we) begin
      lab_mem[lab_wa] <= lab_wd;
    end
    lab_rd <= lab_mem[r];
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_cnt == node_t'(NODES - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_tvalid && in_kind == KIND_RESOLVE) state_next = ST_WALK;
      end
      ST_WALK: begin
        if (node_rd.root) state_next = ST_LABEL;
        else if (steps == step_t'(MAX_NODES)) state_next = ST_NO_ROOT;
      end
      ST_LABEL: begin
        if (!lab_rd.valid) state_next = ST_EMIT_NEW;
        else if (r != node_q) state_next = ST_EMIT_MEM;
        else state_next = ST_IDLE;
      end
      ST_EMIT_NEW: begin
        if (out_free) state_next = (r != node_q) ? ST_EMIT_MEM : ST_IDLE;
      end
      ST_EMIT_MEM: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_NO_ROOT: begin
        if (out_free) state_next = ST_IDLE;
      end
    endcase
  end

  // outputs and memory controls
  always_comb begin
    s_tready = 1'b0;
    node_ra  = r;
    node_we  = 1'b0;
    node_wd  = '{parent: in_parent, root: in_root};
    lab_we   = 1'b0;
    lab_wa   = r;
    lab_wd   = '{valid: 1'b0, label: next_label[LABEL_W-1:0]};
    out_load = 1'b0;
    out_word = '{last: 1'b1, no_root: 1'b0, new_cluster: 1'b0,
                 member_index: node_q, cluster_label: lab};
    unique case (state)
      ST_CLEAR: begin
        lab_we = 1'b1;
        lab_wa = clr_cnt;
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        node_ra  = in_node;
        if (s_tvalid && in_kind == KIND_LOAD) begin
          node_we = 1'b1;
          lab_we  = 1'b1;
          lab_wa  = in_node;
        end
      end
      ST_WALK: begin
        node_ra = node_rd.parent;
      end
      ST_LABEL: begin
        if (!lab_rd.valid) begin
          lab_we = 1'b1;
          lab_wd = '{valid: 1'b1, label: next_label[LABEL_W-1:0]};
        end
      end
      ST_EMIT_NEW: begin
        out_load = out_free;
        out_word = '{last: (r == node_q), no_root: 1'b0, new_cluster: 1'b1,
                     member_index: r, cluster_label: lab};
      end
      ST_EMIT_MEM: begin
        out_load = out_free;
      end
      ST_NO_ROOT: begin
        out_load = out_free;
        out_word = '{last: 1'b1, no_root: 1'b1, new_cluster: 1'b0,
                     member_index: node_q, cluster_label: '0};
      end
    endcase
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_cnt    <= '0;
      next_label <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_cnt <= clr_cnt + node_t'(1);
      if (state == ST_LABEL && !lab_rd.valid) next_label <= next_label + lab_cnt_t'(1);
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (accept && in_kind == KIND_RESOLVE) begin
      node_q <= in_node;
      r      <= in_node;
      steps  <= '0;
    end else if (state == ST_WALK && !node_rd.root && steps != step_t'(MAX_NODES)) begin
      r     <= node_rd.parent;
      steps <= steps + step_t'(1);
    end
    if (state == ST_LABEL) begin
      lab <= lab_rd.valid ? lab_rd.label : next_label[LABEL_W-1:0];
    end
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_q <= out_word;
  end

  assign m_tdata = {(OUT_DATA_W - (2 * NODE_W + 2))'(0), out_q.no_root, out_q.new_cluster,
                    out_q.member_index, out_q.cluster_label};
  assign m_tlast = out_q.last;

  `ASSERT_SAME(a_no_accept_in_clear, clk, rst, state == ST_CLEAR, !s_tready)
  `ASSERT_SAME(a_walk_bound, clk, rst, state == ST_WALK, steps <= step_t'(MAX_NODES))
  `ASSERT_NEXT(a_label_count, clk, rst, state == ST_LABEL && !lab_rd.valid,
               next_label == lab_cnt_t'($past(next_label) + lab_cnt_t'(1)))
  `ASSERT_SAME(a_load_when_free, clk, rst, out_load, out_free)

endmodule
`default_nettype wire

FILE: bench/forest_root_cluster_labeling_top_test.sv
`default_nettype none
module forest_root_cluster_labeling_top_test import frcl_pkg::*; ();

  localparam int STUCK_LIMIT = 20000;
  localparam int RANDOM_WORDS = 680;
  localparam int WRAP_PAIRS = 100;
  localparam int HOLD_AFTER = 400;
  localparam int HOLD_CYCLES = 500;

  typedef struct {
    kind_t kind;
    node_t node;
    node_t parent;
    logic  root;
  } forest_word_t;

  typedef struct packed {
    label_t lab;
    node_t  member;
    logic   fresh;
    logic   noroot;
    logic   fin;
  } member_rec_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // node_index, parent_index, is_root
  logic                  s_tuser = 1'b0; // kind
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // cluster_label, member_index, new_cluster, no_root
  logic                  m_tlast;

  forest_root_cluster_labeling_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // stimulus side: shadow of what has been loaded, used to keep walks on written entries
  forest_word_t pending_words[$];
  node_t        gen_parent[NODES];
  bit           gen_root[NODES];
  bit           gen_loaded[NODES];
  node_t        loaded_nodes[$];

  // forest predictor
  node_t       parent_mem[NODES];
  bit          root_mem[NODES];
  bit          label_ok[NODES];
  label_t      label_mem[NODES];
  lab_cnt_t    label_count = '0;
  member_rec_t labels_due[$];

  int          errors = 0;
  int          words_taken = 0;
  int          total_words = 0;
  logic        in_took = 1'b0;
  int          tx_wait = 0;
  bit          tx_calm = 1'b0;
  forest_word_t tx_word;
  int          rx_wait = 0;
  int          rx_n;
  bit          rx_calm = 1'b0;
  int          hold_left = 0;
  bit          held_once = 1'b0;
  int          stuck = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  function automatic int idle_len(input bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bit walk_is_safe(input node_t n);
    node_t r;
    r = n;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (!gen_loaded[r]) return 1'b0;
      if (gen_root[r]) return 1'b1;
      r = gen_parent[r];
    end
    return gen_loaded[r];
  endfunction

  task automatic load_node(input node_t n, input node_t p, input logic rf);
    forest_word_t w;
    w.kind = KIND_LOAD;
    w.node = n;
    w.parent = p;
    w.root = rf;
    pending_words = {pending_words, w};
    gen_parent[n] = p;
    gen_root[n] = rf;
    if (!gen_loaded[n]) begin
      gen_loaded[n] = 1'b1;
      loaded_nodes = {loaded_nodes, n};
    end
  endtask

  // parent and root bits of a resolve word are don't-care, so fill them at random
  task automatic resolve_node(input node_t n);
    forest_word_t w;
    if (walk_is_safe(n)) begin
      w.kind = KIND_RESOLVE;
      w.node = n;
      w.parent = node_t'($urandom);
      w.root = $urandom_range(0, 1);
      pending_words = {pending_words, w};
    end
  endtask

  function automatic node_t any_loaded();
    return loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
  endfunction

  task automatic fill_words();
    node_t chain[$];
    node_t rn;
    node_t nd;
    int    k;
    int    r;
    int    goal;
    int    cycles_made;
    cycles_made = 0;
    // directed: extremes, shared root, relabel after reload, walk without a root
    load_node(0, 1023, 1'b1);
    load_node(1023, 0, 1'b0);
    resolve_node(1023);
    resolve_node(0);
    load_node(5, 5, 1'b1);
    resolve_node(5);
    load_node(1023, 5, 1'b0);
    resolve_node(1023);
    load_node(10, 11, 1'b0);
    load_node(11, 10, 1'b0);
    resolve_node(10);
    load_node(0, 0, 1'b1);
    resolve_node(0);
    resolve_node(1023);
    resolve_node(11);
    // a burst of fresh roots, each labeled right away
    for (int i = 0; i < WRAP_PAIRS; i++) begin
      rn = node_t'($urandom);
      load_node(rn, node_t'($urandom), 1'b1);
      resolve_node(rn);
    end
    goal = pending_words.size() + RANDOM_WORDS;
    while (pending_words.size() < goal) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        rn = node_t'($urandom);
        chain.delete();
        load_node(rn, node_t'($urandom), 1'b1);
        chain = {chain, rn};
        for (int i = 0; i < k; i++) begin
          nd = node_t'($urandom);
          load_node(nd, chain[$], 1'b0);
          chain = {chain, nd};
        end
        for (int i = $urandom_range(1, chain.size()); i > 0; i--)
          resolve_node(chain[$urandom_range(0, chain.size() - 1)]);
      end else if (r < 70) begin
        resolve_node(any_loaded());
      end else if (r < 85) begin
        load_node(any_loaded(), any_loaded(), $urandom_range(0, 3) == 0);
      end else if (r < 97) begin
        load_node(node_t'($urandom), node_t'($urandom), $urandom_range(0, 1));
      end else if (cycles_made < 4) begin
        // two-node loop with no root, each walk takes the full bound
        rn = node_t'($urandom);
        nd = rn ^ node_t'($urandom_range(1, NODES - 1));
        load_node(rn, nd, 1'b0);
        load_node(nd, rn, 1'b0);
        resolve_node(rn);
        cycles_made++;
      end
    end
    total_words = pending_words.size();
  endtask

  task automatic report(input string what, input member_rec_t want, input member_rec_t got);
    errors++;
    if (errors <= 10)
      $display({"%s: want label %0d member %0d new %0d noroot %0d last %0d, ",
                "got label %0d member %0d new %0d noroot %0d last %0d"},
               what, want.lab, want.member, want.fresh, want.noroot, want.fin,
               got.lab, got.member, got.fresh, got.noroot, got.fin);
  endtask

  task automatic append_due(input member_rec_t rec);
    labels_due = {labels_due, rec};
  endtask

  task automatic take_word(input kind_t k, input node_t n, input node_t p, input logic rf);
    node_t  r;
    int     steps;
    label_t lab;
    if (k == KIND_LOAD) begin
      parent_mem[n] = p;
      root_mem[n] = rf;
      label_ok[n] = 1'b0;
      return;
    end
    r = n;
    steps = 0;
    while (steps < MAX_NODES && !root_mem[r]) begin
      r = parent_mem[r];
      steps++;
    end
    if (!root_mem[r]) begin
      append_due('{lab: '0, member: n, fresh: 1'b0, noroot: 1'b1, fin: 1'b1});
      return;
    end
    if (!label_ok[r]) begin
      lab = label_count[LABEL_W-1:0];
      label_mem[r] = lab;
      label_ok[r] = 1'b1;
      label_count = label_count + 1'b1;
      append_due('{lab: lab, member: r, fresh: 1'b1, noroot: 1'b0, fin: r == n});
    end
    if (r != n)
      append_due('{lab: label_mem[r], member: n, fresh: 1'b0, noroot: 1'b0, fin: 1'b1});
  endtask

  task automatic check_result(input member_rec_t got);
    member_rec_t want;
    if (labels_due.size() == 0) begin
      report("unexpected word", '0, got);
    end else begin
      want = labels_due.pop_front();
      if (want.lab != got.lab || want.member != got.member || want.fresh != got.fresh ||
          want.noroot != got.noroot || want.fin != got.fin)
        report("mismatch", want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_took <= 1'b0;
    end else begin
      in_took <= s_tvalid && s_tready;
      if (m_tvalid && m_tready)
        check_result('{lab: m_tdata[9:0], member: m_tdata[19:10], fresh: m_tdata[20],
                       noroot: m_tdata[21], fin: m_tlast});
      if (s_tvalid && s_tready) begin
        take_word(kind_t'(s_tuser), s_tdata[9:0], s_tdata[19:10], s_tdata[20]);
        words_taken = words_taken + 1;
      end
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !in_took) begin
      // word still on offer
    end else if (tx_wait > 0) begin
      tx_wait <= tx_wait - 1;
      s_tvalid <= 1'b0;
    end else if (pending_words.size() != 0) begin
      tx_word = pending_words.pop_front();
      s_tvalid <= 1'b1;
      s_tdata <= {3'b000, tx_word.root, tx_word.parent, tx_word.node};
      s_tuser <= tx_word.kind;
      tx_wait <= idle_len(tx_calm);
      if ($urandom_range(0, 149) == 0) tx_calm <= !tx_calm;
    end else begin
      s_tvalid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (!held_once && words_taken >= HOLD_AFTER) begin
      // long back-pressure while the sender keeps offering
      hold_left <= HOLD_CYCLES;
      held_once <= 1'b1;
      m_tready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      m_tready <= 1'b0;
    end else begin
      rx_n = ($urandom_range(0, 3) == 0) ? idle_len(rx_calm) : 0;
      if (rx_n == 0) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b0;
        rx_wait <= rx_n - 1;
      end
      if ($urandom_range(0, 299) == 0) rx_calm <= !rx_calm;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stuck <= 0;
    end else if (stuck == STUCK_LIMIT) begin
      $display("forest_root_cluster_labeling_top_test: done, errors");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  initial begin
    fill_words();
    wait (words_taken == total_words);
    wait (labels_due.size() == 0);
    repeat (100) @(posedge clk);
    if (labels_due.size() != 0) errors++;
    if (errors == 0) begin
      $display("forest_root_cluster_labeling_top_test: done, clean");
    end else begin
      $display("forest_root_cluster_labeling_top_test: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
